### src/swtp_pkg.sv
package swtp_pkg;

	// Default number of entries the stack holds.
	localparam int DEFAULT_DEPTH = 32;

	// Widths of the item fields.
	localparam int NAME_W  = 32;
	localparam int KIND_W  = 8;
	localparam int VALUE_W = 32;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	// One stored entry. The name sits in the lowest bits so that the packed
	// struct lines up with the stream data word.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [KIND_W-1:0]         kind;
		logic [NAME_W-1:0]         name;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_REMOVE = 3'd3,
		OP_DRAIN  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// What every cell of the chain does in a cycle.
	typedef enum logic [1:0] {
		MODE_HOLD = 2'd0,
		MODE_PUSH = 2'd1,
		MODE_UP   = 2'd2
	} cell_mode_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_WALK  = 2'd1,
		FSM_FLUSH = 2'd2
	} fsm_state_t;

endpackage

### src/swtp_cell.sv
module swtp_cell (
	input  logic                clk,
	input  swtp_pkg::cell_mode_t mode,
	input  logic                wr_sel,
	input  swtp_pkg::entry_t    above,
	input  swtp_pkg::entry_t    below,
	input  swtp_pkg::entry_t    top_in,
	output swtp_pkg::entry_t    q
);
	import swtp_pkg::*;

	entry_t entry_q;

	// A push moves every entry one place away from the top; a shift up moves
	// it one place toward the top, except for the one cell that takes the
	// kept top entry back during a filtered walk.
	always_ff @(posedge clk) begin
		case (mode)
			MODE_PUSH: begin
				entry_q <= above;
			end
			MODE_UP: begin
				entry_q <= wr_sel ? top_in : below;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign q = entry_q;

endmodule

### src/stack_with_threshold_purge.sv
// Bounded LIFO stack of tagged items, built as a chain of STACK_DEPTH cells
// with the top of the stack in cell 0. Each input item carries an operation
// on s_tuser and a name, kind and signed value on s_tdata. A push gives no
// result unless the stack is full, in which case the item is dropped and a
// full-error result comes out. Pop and peek report the top entry (or an
// empty-error result). Remove-above and drain walk the chain one entry per
// cycle while the output register is free, and then hand out the final
// result. Remove-above reports, from top to bottom, every entry whose value
// is greater than the threshold and rotates the kept entries back into
// place, so they stay in their original order. Every run of results ends
// with m_tlast high. Error results carry zero in all data fields. The input
// side is only ready while no operation is in progress; the output register
// lets the last result wait for the consumer while the next item is accepted.
module stack_with_threshold_purge #(
	parameter int STACK_DEPTH = swtp_pkg::DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // item_name [31:0], item_kind [39:32], item_value [71:40]
	input  logic [7:0]  s_tuser,  // op [2:0], zero above
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // out_name [31:0], out_kind [39:32], out_value [71:40]
	output logic [7:0]  m_tuser,  // status [1:0], zero above
	output logic        m_tlast
);
	import swtp_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	// Cell chain.
	entry_t     cell_q   [STACK_DEPTH];
	entry_t     above_w  [STACK_DEPTH];
	entry_t     below_w  [STACK_DEPTH];
	logic       wr_sel_w [STACK_DEPTH];
	cell_mode_t mode;
	logic       keep_wr;

	// Control state.
	fsm_state_t    state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] r_q;
	logic signed [VALUE_W-1:0] thr_q;
	op_t           op_q;

	// Result held back until it is known whether it is the last one.
	logic    pend_v_q;
	entry_t  pend_q;
	status_t pend_stat_q;
	logic    pend_ld;
	entry_t  pend_item;
	status_t pend_stat;

	// Output register.
	logic    m_valid_q;
	entry_t  out_q;
	status_t out_stat_q;
	logic    out_last_q;
	logic    out_ld;
	logic    out_last;

	entry_t  in_item;
	op_t     op_in;
	entry_t  top;
	logic    accept;
	logic    out_free;
	logic    emit;
	logic    step_last;
	logic [CW-1:0] wpos;
	logic [CW-1:0] r_next;

	assign in_item  = entry_t'(s_tdata);
	assign op_in    = op_t'(s_tuser[OP_W-1:0]);
	assign top      = cell_q[0];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// During a walk, drain reports everything; remove-above reports entries
	// whose value lies above the threshold.
	assign emit      = (op_q == OP_DRAIN) || (top.value > thr_q);
	assign step_last = (k_q == n_q - CW'(1));
	assign r_next    = r_q + CW'(emit);

	// A kept entry goes just below the entries already rotated back, which
	// is the lowest place not yet given up by removed entries.
	assign wpos = n_q - CW'(1) - r_q;

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_top
				assign above_w[gi] = in_item;
			end else begin : g_mid
				assign above_w[gi] = cell_q[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_bot
				assign below_w[gi] = '0;
			end else begin : g_up
				assign below_w[gi] = cell_q[gi+1];
			end
			assign wr_sel_w[gi] = keep_wr && (wpos[IW-1:0] == IW'(gi));

			swtp_cell u_cell (
				.clk    (clk),
				.mode   (mode),
				.wr_sel (wr_sel_w[gi]),
				.above  (above_w[gi]),
				.below  (below_w[gi]),
				.top_in (top),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_PUSH: begin
							if (count_q >= CW'(STACK_DEPTH)) state_d = FSM_FLUSH;
						end
						OP_POP, OP_PEEK: begin
							state_d = FSM_FLUSH;
						end
						OP_REMOVE, OP_DRAIN: begin
							if (count_q != '0) state_d = FSM_WALK;
						end
						default: begin
							state_d = FSM_IDLE;
						end
					endcase
				end
			end
			FSM_WALK: begin
				if (out_free && step_last) begin
					state_d = (pend_v_q || emit) ? FSM_FLUSH : FSM_IDLE;
				end
			end
			FSM_FLUSH: begin
				if (out_free) state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		s_tready  = (state_q == FSM_IDLE);
		mode      = MODE_HOLD;
		keep_wr   = 1'b0;
		pend_ld   = 1'b0;
		pend_item = '0;
		pend_stat = STAT_OK;
		out_ld    = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_PUSH: begin
							if (count_q < CW'(STACK_DEPTH)) begin
								mode = MODE_PUSH;
							end else begin
								pend_ld   = 1'b1;
								pend_stat = STAT_FULL;
							end
						end
						OP_POP, OP_PEEK: begin
							pend_ld = 1'b1;
							if (count_q == '0) begin
								pend_stat = STAT_EMPTY;
							end else begin
								pend_item = top;
								if (op_in == OP_POP) mode = MODE_UP;
							end
						end
						default: begin
							mode = MODE_HOLD;
						end
					endcase
				end
			end
			FSM_WALK: begin
				if (out_free) begin
					mode = MODE_UP;
					if (emit) begin
						pend_ld   = 1'b1;
						pend_item = top;
						// The earlier result now has a successor.
						out_ld    = pend_v_q;
					end else begin
						keep_wr = 1'b1;
					end
				end
			end
			FSM_FLUSH: begin
				if (out_free) begin
					out_ld   = 1'b1;
					out_last = 1'b1;
				end
			end
			default: begin
				mode = MODE_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			count_q   <= '0;
			pend_v_q  <= 1'b0;
			m_valid_q <= 1'b0;
			n_q       <= '0;
			k_q       <= '0;
			r_q       <= '0;
			op_q      <= OP_PUSH;
		end else begin
			state_q <= state_d;

			if (state_q == FSM_IDLE && accept) begin
				n_q  <= count_q;
				k_q  <= '0;
				r_q  <= '0;
				op_q <= op_in;
				if (op_in == OP_PUSH && count_q < CW'(STACK_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end else if (op_in == OP_POP && count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end else if (state_q == FSM_WALK && out_free) begin
				k_q <= k_q + CW'(1);
				r_q <= r_next;
				if (step_last) count_q <= n_q - r_next;
			end

			if (pend_ld) begin
				pend_v_q <= 1'b1;
			end else if (state_q == FSM_FLUSH && out_free) begin
				pend_v_q <= 1'b0;
			end

			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && accept) thr_q <= in_item.value;
		if (pend_ld) begin
			pend_q      <= pend_item;
			pend_stat_q <= pend_stat;
		end
		if (out_ld) begin
			out_q      <= pend_q;
			out_stat_q <= pend_stat_q;
			out_last_q <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = {6'd0, out_stat_q};
	assign m_tlast  = out_last_q;

	// The stack never holds more entries than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("fill count above stack depth");

	// A held-back result exists only while an operation is in progress.
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q != FSM_IDLE))
		else $error("pending result while idle");

	// A walk only starts on a non-empty stack.
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK) |-> (n_q != '0) && (k_q < n_q))
		else $error("walk past the held entries");

	// An error result is always the only result of its item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_stat_q != STAT_OK) |-> out_last_q)
		else $error("error result not marked last");

	// The flush state always has a result to hand out.
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_FLUSH) |-> pend_v_q)
		else $error("flush without a pending result");

endmodule

### sim/stack_with_threshold_purge_tb.sv
`timescale 1ns / 1ps

module stack_with_threshold_purge_tb;

	import swtp_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;

	// A watchdog ends the run after this many cycles in which neither side
	// moves an item. The slowest legal stretch is a full walk of the stack
	// with every result held back by a busy receiver, far below this.
	localparam int WATCHDOG_LIMIT = 4000;

	// Cycles to linger once nothing is expected, a little more than one walk
	// over a full stack, so that a stray late result is still caught.
	localparam int SETTLE_CYCLES = DEPTH + 8;

	// Op codes past the last defined one; the block must ignore them.
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

	// One result the block owes us: status, reported entry and end mark.
	typedef struct packed {
		status_t status;
		entry_t  entry;
		logic    last;
	} report_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // item_name [31:0], item_kind [39:32], item_value [71:40]
	logic [7:0]  s_tuser;  // op [2:0], zero above
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;  // out_name [31:0], out_kind [39:32], out_value [71:40]
	logic [7:0]  m_tuser;  // status [1:0], zero above
	logic        m_tlast;

	// Shadow copy of the stack, index 0 at the bottom, and the results the
	// block still owes, oldest first.
	entry_t  model_entries[$];
	report_t expected_reports[$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int tx_idle_pct    = 24;
	int rx_idle_pct    = 78;

	stack_with_threshold_purge #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver decides at each falling edge whether it takes a result
	// at the next rising edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Queue the report an error result stands for.
	function automatic void owe_error(input status_t status);
		report_t rep;
		rep.status = status;
		rep.entry  = '0;
		rep.last   = 1'b0;
		expected_reports.push_back(rep);
	endfunction

	function automatic void owe_entry(input entry_t entry);
		report_t rep;
		rep.status = STAT_OK;
		rep.entry  = entry;
		rep.last   = 1'b0;
		expected_reports.push_back(rep);
	endfunction

	// Apply one accepted item to the shadow stack and queue the results it
	// causes. The final result of the item carries the end mark.
	function automatic void stack_model_apply(input logic [OP_W-1:0] op,
		input entry_t item);
		int     owed_before;
		entry_t kept[$];
		owed_before = expected_reports.size();
		case (op)
			OP_PUSH: begin
				if (model_entries.size() >= DEPTH)
					owe_error(STAT_FULL);
				else
					model_entries.push_back(item);
			end
			OP_POP, OP_PEEK: begin
				if (model_entries.size() == 0) begin
					owe_error(STAT_EMPTY);
				end else begin
					owe_entry(model_entries[$]);
					if (op == OP_POP)
						void'(model_entries.pop_back());
				end
			end
			OP_REMOVE: begin
				// Report from the top down, then keep the rest in order.
				for (int i = model_entries.size() - 1; i >= 0; i--) begin
					if ($signed(model_entries[i].value) > $signed(item.value))
						owe_entry(model_entries[i]);
				end
				foreach (model_entries[i]) begin
					if (!($signed(model_entries[i].value) > $signed(item.value)))
						kept.push_back(model_entries[i]);
				end
				model_entries = kept;
			end
			OP_DRAIN: begin
				while (model_entries.size() != 0)
					owe_entry(model_entries.pop_back());
			end
			default: begin
				// Unused codes leave everything as it is.
			end
		endcase
		if (expected_reports.size() > owed_before)
			expected_reports[expected_reports.size() - 1].last = 1'b1;
	endfunction

	// Values cluster on the signed extremes and around zero so that
	// threshold compares hit their edges often.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: begin
				return {1'b1, {(VALUE_W-1){1'b0}}};
			end
			1: begin
				return {1'b0, {(VALUE_W-1){1'b1}}};
			end
			2, 3: begin
				return int'($urandom_range(20)) - 10;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// While growing, pushes dominate so the stack fills up and overflows;
	// while shrinking, reads and the walking operations take over.
	function automatic logic [OP_W-1:0] choose_op(input bit grow);
		int r;
		r = $urandom_range(99);
		if (grow) begin
			if (r < 75) return OP_PUSH;
			if (r < 83) return OP_POP;
			if (r < 90) return OP_PEEK;
			if (r < 94) return OP_REMOVE;
			if (r < 96) return OP_DRAIN;
		end else begin
			if (r < 25) return OP_PUSH;
			if (r < 55) return OP_POP;
			if (r < 65) return OP_PEEK;
			if (r < 85) return OP_REMOVE;
			if (r < 95) return OP_DRAIN;
		end
		return OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
	endfunction

	// Offer one item, starting at a falling edge, and hold it until the block
	// takes it. Idle cycles come first, at the current sender idle rate. The
	// task returns at the falling edge after the handshake, with valid still
	// high, so an item that follows with no idle cycles keeps valid high in between.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [NAME_W-1:0] name,
		input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] value);
		entry_t item;
		item.name  = name;
		item.kind  = kind;
		item.value = value;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = item;
		s_tuser  = {5'b0, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		stack_model_apply(op, item);
		@(negedge clk);
	endtask

	// Stop offering items and wait until every owed result has come back.
	task automatic wait_reports_done();
		s_tvalid = 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Reads and walks on an empty stack, and the unused op codes.
	task automatic test_empty_stack();
		send_item(OP_POP, '1, '1, -1);
		send_item(OP_PEEK, '0, '0, 0);
		send_item(OP_DRAIN, '0, '0, 0);
		send_item(OP_REMOVE, '0, '0, {1'b1, {(VALUE_W-1){1'b0}}});
		send_item(OP_FIRST_UNUSED, '1, '1, -1);
		send_item(OP_LAST_UNUSED, 32'h1234_5678, 8'h9a, 7);
		wait_reports_done();
	endtask

	// Field extremes pushed and read back, then thresholds at the limits.
	task automatic test_field_extremes();
		send_item(OP_PUSH, 32'h0000_0000, 8'h00, {1'b1, {(VALUE_W-1){1'b0}}});
		send_item(OP_PUSH, 32'hffff_ffff, 8'hff, {1'b0, {(VALUE_W-1){1'b1}}});
		send_item(OP_PUSH, 32'ha5a5_a5a5, 8'h5a, -1);
		send_item(OP_PUSH, 32'h5a5a_5a5a, 8'ha5, 0);
		send_item(OP_PUSH, 32'h8000_0001, 8'h81, 1);
		send_item(OP_PEEK, '0, '0, 0);
		// Nothing can exceed the largest value, so nothing leaves.
		send_item(OP_REMOVE, '0, '0, {1'b0, {(VALUE_W-1){1'b1}}});
		// Only the positive entries go, and the rest close up in order.
		send_item(OP_REMOVE, '0, '0, 0);
		send_item(OP_POP, '0, '0, 0);
		send_item(OP_PUSH, 32'h0f0f_0f0f, 8'hf0, 2);
		// Everything but the most negative entry leaves.
		send_item(OP_REMOVE, '0, '0, {1'b1, {(VALUE_W-1){1'b0}}});
		send_item(OP_DRAIN, '0, '0, 0);
		wait_reports_done();
	endtask

	// Fill to the brim, overflow twice, then purge the entries above the middle entry's value and drain the rest.
	task automatic test_full_stack();
		while (model_entries.size() < DEPTH)
			send_item(OP_PUSH, $urandom, KIND_W'($urandom_range(255)), pick_value());
		repeat (2)
			send_item(OP_PUSH, $urandom, KIND_W'($urandom_range(255)), pick_value());
		send_item(OP_PEEK, '0, '0, 0);
		send_item(OP_REMOVE, '0, '0, model_entries[DEPTH/2].value);
		send_item(OP_DRAIN, '0, '0, 0);
		wait_reports_done();
	endtask

	// Random traffic that swings between growing and shrinking phases.
	// Thresholds are often taken from a held value so that purges actually
	// remove something. Ignored op codes do not count toward the goal.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct,
		input int item_goal);
		int                        counted;
		bit                        grow;
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
		counted     = 0;
		grow        = 1'b1;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (counted < item_goal) begin
			if ($urandom_range(19) == 0)
				grow = !grow;
			op    = choose_op(grow);
			value = pick_value();
			if (op == OP_REMOVE && model_entries.size() != 0 && $urandom_range(1) == 1) begin
				value = model_entries[$urandom_range(model_entries.size() - 1)].value;
				value = value - int'($urandom_range(1));
			end
			send_item(op, $urandom, KIND_W'($urandom_range(255)), value);
			if (op <= OP_DRAIN)
				counted++;
		end
		wait_reports_done();
	endtask

	// Every result taken is checked against the oldest one owed.
	always @(posedge clk) begin : check_results
		report_t want;
		entry_t  got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_reports.size() == 0) begin
				$error("unexpected result: status %0d name %h", m_tuser[STAT_W-1:0], got.name);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (m_tuser[STAT_W-1:0] !== want.status) begin
					$error("status expected %0d got %0d", want.status, m_tuser[STAT_W-1:0]);
					mismatch_count++;
				end
				if (got.name !== want.entry.name) begin
					$error("out_name expected %h got %h", want.entry.name, got.name);
					mismatch_count++;
				end
				if (got.kind !== want.entry.kind) begin
					$error("out_kind expected %h got %h", want.entry.kind, got.kind);
					mismatch_count++;
				end
				if (got.value !== want.entry.value) begin
					$error("out_value expected %0d got %0d", $signed(want.entry.value),
						$signed(got.value));
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last expected %b got %b", want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a long stretch with no item moving on either side means the
	// block has hung.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_stack();
		test_field_extremes();
		test_full_stack();
		test_random_traffic(24, 78, 90);
		test_random_traffic(78, 24, 90);
		test_random_traffic(0, 0, 90);

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (expected_reports.size() != 0) begin
			$error("%0d results never arrived", expected_reports.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
